// ===== hdl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

    localparam int MaxRoundsDefault = 14;
    localparam int BlockW = 128;

    // register indexes
    localparam logic [2:0] RegKey0 = 3'd0;
    localparam logic [2:0] RegKey1 = 3'd1;
    localparam logic [2:0] RegKey2 = 3'd2;
    localparam logic [2:0] RegKey3 = 3'd3;
    localparam logic [2:0] RegKeySize = 3'd4;

    localparam logic ActEncrypt = 1'b0;
    localparam logic ActDecrypt = 1'b1;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic   act;
        logic   last;
        t_block st;
    } t_stage;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // column bytes in low-to-high order
    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[7:0]; a1 = w[15:8]; a2 = w[23:16]; a3 = w[31:24];
        mix_col = {gmul(a0, 4'd3) ^ a1 ^ a2 ^ gmul(a3, 4'd2),
                   a0 ^ a1 ^ gmul(a2, 4'd2) ^ gmul(a3, 4'd3),
                   a0 ^ gmul(a1, 4'd2) ^ gmul(a2, 4'd3) ^ a3,
                   gmul(a0, 4'd2) ^ gmul(a1, 4'd3) ^ a2 ^ a3};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[7:0]; a1 = w[15:8]; a2 = w[23:16]; a3 = w[31:24];
        inv_mix_col = {
            gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14),
            gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11),
            gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13),
            gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9)};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_if.sv =====
`default_nettype none
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] block_in_low;
    logic [63:0] block_in_high;
    logic        last_block;
    modport source (output valid, action, block_in_low, block_in_high, last_block,
                    input ready);
    modport sink (input valid, action, block_in_low, block_in_high, last_block,
                  output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out_low;
    logic [63:0] block_out_high;
    logic        last_out;
    modport source (output valid, block_out_low, block_out_high, last_out, input ready);
    modport sink (input valid, block_out_low, block_out_high, last_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/aes_keyexp.sv =====
`default_nettype none
module aes_keyexp
    import aes_pkg::*;
#(
    parameter int MAX_ROUNDS = MaxRoundsDefault
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [255:0]                  i_key,
    input  wire logic [1:0]                    i_key_size,
    output logic [$clog2(MAX_ROUNDS+1)-1:0]    o_rounds,
    output logic                               o_busy,
    output logic [4*(MAX_ROUNDS+1)*32-1:0]     o_fwd,
    output logic [4*(MAX_ROUNDS+1)*32-1:0]     o_inv
);
    localparam int Words = 4 * (MAX_ROUNDS + 1);
    localparam int WIdxW = $clog2(Words + 1);
    localparam int RndW = $clog2(MAX_ROUNDS + 1);

    // key words, one generated per cycle
    logic [31:0]      r_w [Words];
    logic [WIdxW-1:0] r_idx;
    logic [WIdxW-1:0] r_total;
    logic [3:0]       r_nk;
    logic [3:0]       r_mod;
    logic [7:0]       r_rcon;
    logic             r_busy;
    logic [RndW-1:0]  r_nr;

    logic [1:0]  sel;
    logic [3:0]  nk_s;
    logic [4:0]  nr_full;
    logic [RndW-1:0] nr_s;
    logic [31:0] prev, back, t, n_word;

    // reset always expands a 128-bit key
    always_comb begin
        sel = (!i_rst_n) ? 2'd0 : ((i_key_size == 2'd3) ? 2'd2 : i_key_size);
        nk_s = 4'd4 + {1'b0, sel, 1'b0};
        nr_full = 5'd10 + {2'b0, sel, 1'b0};
        nr_s = (nr_full > 5'(MAX_ROUNDS)) ? RndW'(MAX_ROUNDS) : RndW'(nr_full);
    end

    // word recurrence; indexes stay inside the array while busy
    always_comb begin
        prev = r_w[(r_idx == '0) ? '0 : r_idx[WIdxW-1:0] - 1'b1 < Words ?
                   r_idx - 1'b1 : '0];
        back = r_w[(r_idx >= WIdxW'(r_nk)) ? r_idx - WIdxW'(r_nk) : '0];
        t = prev;
        if (r_mod == 4'd0) begin
            t = sub_word({prev[7:0], prev[31:8]}) ^ {24'h0, r_rcon};
        end else if (r_nk > 4'd6 && r_mod == 4'd4) begin
            t = sub_word(prev);
        end
        n_word = back ^ t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_idx <= WIdxW'(nk_s);
            r_total <= WIdxW'(4 * (int'(nr_s) + 1));
            r_nk <= nk_s;
            r_mod <= 4'd0;
            r_rcon <= 8'h01;
            r_nr <= nr_s;
        end else if (r_busy) begin
            if (r_idx >= r_total - 1'b1) r_busy <= 1'b0;
            r_idx <= r_idx + 1'b1;
            r_mod <= (r_mod + 4'd1 == r_nk) ? 4'd0 : r_mod + 4'd1;
            if (r_mod == 4'd0) r_rcon <= xtime(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            for (int i = 0; i < 8; i++) begin
                if (i < Words) r_w[i] <= (!i_rst_n) ? 32'h0 : i_key[32*i +: 32];
            end
        end else if (r_busy && r_idx < WIdxW'(Words)) begin
            r_w[r_idx] <= n_word;
        end
    end

    assign o_rounds = r_nr;
    assign o_busy = r_busy;

    // forward and inverse key views
    always_comb begin
        for (int r = 0; r <= MAX_ROUNDS; r++) begin
            for (int j = 0; j < 4; j++) begin
                o_fwd[(4*r+j)*32 +: 32] = r_w[4*r+j];
                if (r <= int'(r_nr)) begin
                    o_inv[(4*r+j)*32 +: 32] = (r == 0 || r == int'(r_nr)) ?
                        r_w[4*(int'(r_nr)-r)+j] : inv_mix_col(r_w[4*(int'(r_nr)-r)+j]);
                end else begin
                    o_inv[(4*r+j)*32 +: 32] = 32'h0;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/aes_round.sv =====
`default_nettype none
module aes_round
    import aes_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic         i_vld,
    input  wire t_stage       i_st,
    input  wire logic         i_active,
    input  wire logic         i_final,
    input  wire logic [127:0] i_fkey,
    input  wire logic [127:0] i_ikey,
    output t_stage            o_st,
    output logic              o_vld,
    input  wire logic         i_rst_n
);
    logic [7:0]   s [16];
    logic [7:0]   e [16];
    logic [7:0]   d [16];
    logic [127:0] ef, df, res;

    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = i_st.st[8*i +: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                e[4*c+r] = SBOX[s[4*((c+r)%4)+r]];
                d[4*((c+r)%4)+r] = ISBOX[s[4*c+r]];
            end
        end
        for (int i = 0; i < 16; i++) begin
            ef[8*i +: 8] = e[i];
            df[8*i +: 8] = d[i];
        end
        if (!i_final) begin
            for (int c = 0; c < 4; c++) begin
                ef[32*c +: 32] = mix_col(ef[32*c +: 32]);
                df[32*c +: 32] = inv_mix_col(df[32*c +: 32]);
            end
        end
        if (!i_active) res = i_st.st;
        else if (i_st.act == ActDecrypt) res = df ^ i_ikey;
        else res = ef ^ i_fkey;
    end

    // one round per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else if (i_en) o_vld <= i_vld;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) o_st <= '{act: i_st.act, last: i_st.last, st: res};
    end
endmodule
`default_nettype wire

// ===== hdl/aes_block_cipher.sv =====
// AES block cipher, ECB, 128/192/256-bit keys.
// Input channel (aes_in_if): action (0 encrypt, 1 decrypt), block, last flag.
// Output channel (aes_out_if): result block and copied last flag.
// Keys are written over APB: key parts at 0x00..0x18, key size at 0x20.
// A key write reruns the key schedule, one word per cycle, started by a
// registered strobe; i_in.ready stays low until it has settled.
// Pipeline: one whitening stage plus MAX_ROUNDS round stages for every key
// size; shorter keys pass the spare stages unchanged. Throughput is one
// block per cycle while results are taken and no key schedule runs.
// When the receiver stalls the whole pipeline holds; while the last stage
// is empty the pipeline advances, so a stall drops i_in.ready only while
// the last stage holds an untaken result.
// Reset clears all valid bits and expands the all-zero 128-bit key, which
// keeps i_in.ready low after reset is released until the schedule settles.
`default_nettype none
module aes_block_cipher
    import aes_pkg::*;
#(
    parameter int MAX_ROUNDS = MaxRoundsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    aes_in_if.sink           i_in,
    aes_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    localparam int Words = 4 * (MAX_ROUNDS + 1);
    localparam int RndW = $clog2(MAX_ROUNDS + 1);

    logic [63:0] r_key [4];
    logic [1:0]  r_key_size;
    logic        wr, start;
    logic [2:0]  reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= 64'h0;
            r_key_size <= 2'd0;
        end else if (wr) begin
            case (reg_idx)
                RegKey0: r_key[0] <= pwdata;
                RegKey1: r_key[1] <= pwdata;
                RegKey2: r_key[2] <= pwdata;
                RegKey3: r_key[3] <= pwdata;
                RegKeySize: r_key_size <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    logic r_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_start <= 1'b0;
        else r_start <= wr && (reg_idx <= RegKeySize);
    end
    assign start = r_start;

    always_comb begin
        case (reg_idx)
            RegKey0: prdata = r_key[0];
            RegKey1: prdata = r_key[1];
            RegKey2: prdata = r_key[2];
            RegKey3: prdata = r_key[3];
            RegKeySize: prdata = {62'h0, r_key_size};
            default: prdata = 64'h0;
        endcase
    end

    logic [RndW-1:0]         rounds;
    logic                    kx_busy;
    logic [Words*32-1:0]     fwd, inv;

    aes_keyexp #(.MAX_ROUNDS(MAX_ROUNDS)) u_keyexp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_key({r_key[3], r_key[2], r_key[1], r_key[0]}), .i_key_size(r_key_size),
        .o_rounds(rounds), .o_busy(kx_busy), .o_fwd(fwd), .o_inv(inv)
    );

    // pipeline enable: advance unless the last stage holds a stalled result
    t_stage st  [MAX_ROUNDS+1];
    logic   vld [MAX_ROUNDS+1];
    logic   en;
    logic   in_open;
    t_stage in_st;

    // requests wait while the key schedule is being rebuilt
    assign in_open = !kx_busy && !start;
    assign en = !vld[MAX_ROUNDS] || o_out.ready;
    assign i_in.ready = en && in_open;

    // whitening stage
    always_comb begin
        in_st.act = i_in.action;
        in_st.last = i_in.last_block;
        in_st.st = {i_in.block_in_high, i_in.block_in_low} ^
            ((i_in.action == ActDecrypt) ? inv[127:0] : fwd[127:0]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) vld[0] <= 1'b0;
        else if (en) vld[0] <= i_in.valid && in_open;
    end
    always_ff @(posedge i_clk) begin
        if (en) st[0] <= in_st;
    end

    for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_round
        aes_round u_round (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(vld[g-1]), .i_st(st[g-1]),
            .i_active(RndW'(g) <= rounds), .i_final(RndW'(g) == rounds),
            .i_fkey(fwd[128*g +: 128]), .i_ikey(inv[128*g +: 128]),
            .o_st(st[g]), .o_vld(vld[g])
        );
    end

    assign o_out.valid = vld[MAX_ROUNDS];
    assign o_out.block_out_low = st[MAX_ROUNDS].st[63:0];
    assign o_out.block_out_high = st[MAX_ROUNDS].st[127:64];
    assign o_out.last_out = st[MAX_ROUNDS].last;

    // a stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.block_out_low))
        else $error("result changed under stall");
    // ready only drops behind a waiting result or during key expansion
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready) || !in_open)
        else $error("input stalled without cause");
    // round count within range
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rounds <= RndW'(MAX_ROUNDS))
        else $error("round count out of range");
endmodule
`default_nettype wire

// ===== tb/aes_block_cipher_test.sv =====
`timescale 1ns / 1ps
module aes_block_cipher_test;
    import aes_pkg::*;

    localparam int MaxRounds = 14;
    localparam int RunLimit = 600000;
    localparam int SettleCycles = 90;
    localparam int DrainCycles = 40;
    localparam logic [2:0] RegUnused = 3'd5;

    typedef struct {
        logic        act;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        last;
    } t_cipher_req;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        last;
    } t_cipher_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    aes_in_if  in_ch();
    aes_out_if out_ch();

    aes_block_cipher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // key registers and expanded schedule as the block should hold them
    logic [63:0] key_word [4];
    logic [1:0]  key_len_sel;
    logic [31:0] sched_words [4*(MaxRounds+1)];
    int          round_count;

    t_cipher_req pending_reqs [$];
    t_cipher_res expected_blocks [$];
    int          n_accepted = 0;
    int          n_errors = 0;
    int          cycle_count = 0;
    int          send_gap_max = 7;
    int          recv_stall_max = 7;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // key size three behaves as a 256 bit key
    function automatic void expand_schedule();
        int sel, nk, nr;
        logic [31:0] t;
        logic [7:0] rcon;
        sel = (key_len_sel == 2'd3) ? 2 : int'(key_len_sel);
        nk = 4 + 2 * sel;
        nr = 10 + 2 * sel;
        if (nr > MaxRounds) nr = MaxRounds;
        round_count = nr;
        rcon = 8'h01;
        for (int i = 0; i < 4 * (MaxRounds + 1); i++) sched_words[i] = '0;
        for (int i = 0; i < 4 * (nr + 1); i++) begin
            if (i < nk) begin
                sched_words[i] = key_word[i >> 1][32 * (i & 1) +: 32];
            end else begin
                t = sched_words[i - 1];
                if (i % nk == 0) begin
                    t = sbox_word({t[7:0], t[31:8]}) ^ {24'h0, rcon};
                    rcon = gf_mul(rcon, 8'h02);
                end else if (nk > 6 && i % nk == 4) begin
                    t = sbox_word(t);
                end
                sched_words[i] = sched_words[i - nk] ^ t;
            end
        end
    endfunction

    function automatic logic [127:0] round_key(input int r);
        return {sched_words[4*r+3], sched_words[4*r+2], sched_words[4*r+1], sched_words[4*r]};
    endfunction

    function automatic t_cipher_res cipher_block(input t_cipher_req req);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] blk, k;
        t_cipher_res res;
        blk = {req.hi, req.lo};
        for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8];
        if (req.act == ActEncrypt) begin
            k = round_key(0);
            for (int i = 0; i < 16; i++) s[i] ^= k[8*i +: 8];
            for (int rd = 1; rd <= round_count; rd++) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*c+r] = SBOX[s[4*((c+r)&3)+r]];
                if (rd < round_count) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                        t[4*c]   = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
                        t[4*c+1] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
                        t[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
                        t[4*c+3] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
                    end
                end
                k = round_key(rd);
                for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[8*i +: 8];
            end
        end else begin
            // straight inverse cipher, walking the schedule backwards
            k = round_key(round_count);
            for (int i = 0; i < 16; i++) s[i] ^= k[8*i +: 8];
            for (int rd = round_count - 1; rd >= 0; rd--) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4*((c+r)&3)+r] = ISBOX[s[4*c+r]];
                k = round_key(rd);
                for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[8*i +: 8];
                if (rd > 0) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                                 ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
                        s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                                 ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
                        s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                                 ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
                        s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                                 ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) blk[8*i +: 8] = s[i];
        res.lo = blk[63:0];
        res.hi = blk[127:64];
        res.last = req.last;
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int draw_wait(input int max_wait);
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, max_wait);
    endfunction

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    int          send_gap = 0;
    t_cipher_req cur_req;
    always @(posedge i_clk) begin
        logic busy;
        logic loaded;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.action <= ActEncrypt;
            in_ch.block_in_low <= '0;
            in_ch.block_in_high <= '0;
            in_ch.last_block <= 1'b0;
        end else begin
            busy = in_ch.valid;
            loaded = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                expected_blocks.push_back(cipher_block(cur_req));
                n_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    send_gap = draw_wait(send_gap_max);
                    busy = 1'b1;
                    loaded = 1'b1;
                end
            end
            in_ch.valid <= busy;
            if (loaded) begin
                in_ch.action <= cur_req.act;
                in_ch.block_in_low <= cur_req.lo;
                in_ch.block_in_high <= cur_req.hi;
                in_ch.last_block <= cur_req.last;
            end
        end
    end

    // long receiver hold-off once the stream is going, so the pipeline backs up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // result monitor and receiver stalls
    int recv_stall = 0;
    always @(posedge i_clk) begin
        t_cipher_res exp_res;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                recv_stall = draw_wait(recv_stall_max);
                if (expected_blocks.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result lo=%h hi=%h last=%b",
                                 out_ch.block_out_low, out_ch.block_out_high, out_ch.last_out);
                end else begin
                    exp_res = expected_blocks.pop_front();
                    if (out_ch.block_out_low !== exp_res.lo
                            || out_ch.block_out_high !== exp_res.hi
                            || out_ch.last_out !== exp_res.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: exp lo=%h hi=%h last=%b got lo=%h hi=%h last=%b",
                                     exp_res.lo, exp_res.hi, exp_res.last,
                                     out_ch.block_out_low, out_ch.block_out_high,
                                     out_ch.last_out);
                    end
                end
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
        end
        out_ch.ready <= i_rst_n && (hold_left == 0) && (recv_stall == 0);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RunLimit) begin
            $display("aes_block_cipher verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < RegKeySize) begin
            key_word[idx[1:0]] = value;
            expand_schedule();
        end else if (idx == RegKeySize) begin
            key_len_sel = value[1:0];
            expand_schedule();
        end
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !in_ch.valid && expected_blocks.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] size_word);
        wait_idle();
        reg_write(RegKey0, k0);
        reg_write(RegKey1, k1);
        reg_write(RegKey2, k2);
        reg_write(RegKey3, k3);
        reg_write(RegKeySize, size_word);
        // key schedule reruns after the write
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        t_cipher_req req;
        for (int n = 0; n < count; n++) begin
            req.act = 1'($urandom_range(0, 1));
            req.lo = rand_word();
            req.hi = rand_word();
            req.last = 1'($urandom_range(0, 1));
            pending_reqs.push_back(req);
        end
    endtask

    task automatic queue_one(input logic act, input logic [63:0] lo,
                             input logic [63:0] hi, input logic last);
        t_cipher_req req;
        req.act = act;
        req.lo = lo;
        req.hi = hi;
        req.last = last;
        pending_reqs.push_back(req);
    endtask

    // stimulus sequence
    initial begin
        for (int i = 0; i < 4; i++) key_word[i] = '0;
        key_len_sel = 2'd0;
        expand_schedule();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset expands the all-zero key
        repeat (SettleCycles) @(posedge i_clk);

        // directed: extremes of the block, both directions, last flag
        queue_one(ActEncrypt, '0, '0, 1'b0);
        queue_one(ActDecrypt, '0, '0, 1'b1);
        queue_one(ActEncrypt, '1, '1, 1'b1);
        queue_one(ActDecrypt, '1, '1, 1'b0);
        queue_one(ActEncrypt, 64'h7766554433221100, 64'hffeeddccbbaa9988, 1'b0);
        queue_one(ActDecrypt, 64'h7766554433221100, 64'hffeeddccbbaa9988, 1'b1);
        queue_one(ActEncrypt, 64'h0000000000000001, 64'h8000000000000000, 1'b0);
        queue_one(ActDecrypt, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        queue_one(ActEncrypt, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
        queue_random(40);

        // 128 bit key, unused key parts hold junk that must be ignored;
        // long hold-off lands in here while requests keep coming
        send_gap_max = 0;
        recv_stall_max = 0;
        load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '1, '1, 64'd0);
        queue_random(400);

        // 192 bit key
        send_gap_max = 7;
        recv_stall_max = 7;
        load_key(rand_word(), rand_word(), rand_word(), 64'h0123456789abcdef, 64'd1);
        queue_random(300);

        // 256 bit key, all ones
        send_gap_max = 0;
        recv_stall_max = 7;
        load_key('1, '1, '1, '1, 64'd2);
        queue_random(250);

        // size code three acts as 256, upper bits of the write dropped
        send_gap_max = 7;
        recv_stall_max = 0;
        load_key({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, 64'hfffffffffffffffb);
        queue_random(250);

        // write to an unused register is ignored
        wait_idle();
        reg_write(RegUnused, '1);
        repeat (SettleCycles) @(posedge i_clk);
        queue_random(100);

        // back to 128 bit, all-zero key
        send_gap_max = 7;
        recv_stall_max = 7;
        load_key('0, '0, '0, '0, 64'd0);
        queue_random(250);

        // 256 bit random key
        load_key({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, 64'd2);
        queue_random(250);

        wait_idle();
        if (n_errors == 0) begin
            $display("aes_block_cipher verification clean");
        end else begin
            $display("aes_block_cipher verification failed");
        end
        $finish;
    end

endmodule

// ===== aes_block_cipher.f =====
hdl/aes_pkg.sv
hdl/aes_if.sv
hdl/aes_keyexp.sv
hdl/aes_round.sv
hdl/aes_block_cipher.sv
tb/aes_block_cipher_test.sv
